[rtl/mppt_gt_pkg.sv]
// Package for the gradient tracker: register map, reset values, sequencer states, widths.
package mppt_gt_pkg;

  localparam int unsigned FieldW  = 16;
  localparam int unsigned PowerW  = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned QuoW    = 32;
  localparam int unsigned MagW    = QuoW + 1;
  localparam int unsigned MulAW   = MagW;
  localparam int unsigned MulBW   = FieldW;
  localparam int unsigned MulW    = MulAW + MulBW;
  localparam int unsigned DivCntW = $clog2(QuoW);

  typedef enum logic [CfgIdxW-1:0] {
    REG_STEP_MAX = 3'd0,
    REG_GAIN     = 3'd1,
    REG_DEADBAND = 3'd2,
    REG_MIN_SP   = 3'd3,
    REG_MAX_SP   = 3'd4
  } cfg_reg_e;

  localparam logic [FieldW-1:0] StepMaxRst  = 16'd100;
  localparam logic [FieldW-1:0] GainRst     = 16'd6554;
  localparam logic [FieldW-1:0] DeadbandRst = 16'd5;
  localparam logic [FieldW-1:0] MinSpRst    = 16'd0;
  localparam logic [FieldW-1:0] MaxSpRst    = 16'd15000;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_DIV  = 6'b000100,
    S_SUM  = 6'b001000,
    S_GAIN = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

endpackage

[rtl/mppt_gradient_tracker.sv]
// Incremental-conductance MPPT tracker with a shared multiplier and a bit-serial divider.
//
// Input beats (volt_mv_i, curr_ma_i) are taken when in_valid_i is high and in_stall_o low.
// in_stall_o stays high from acceptance until the result has been handed to the output
// register, so one sample is worked on at a time.
// Result beats are offered on out_valid_o and taken when out_stall_i is low; the fields
// hold steady while stalled. A result waiting in the output register does not block the
// next sample; only the final write of the following sample waits for it to be taken.
// From acceptance to out_valid_o, a sample with a changed voltage passes one multiply,
// 32 restoring-division steps at one quotient bit per cycle, sum, gain multiply and final
// clamp; with an unchanged voltage it goes straight to the final clamp. The divider loop
// is the longest part. A new sample is taken only once the last one has been handed on.
// Configuration writes use cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// cfg_ready_o is always high, indexes past the register list are dropped. Write only
// while the tracker is idle.
// Reset (rst_ni low, asynchronous) restores the register defaults and clears the previous
// sample, the setpoint and the recorded peak; no result is pending afterwards.
module mppt_gradient_tracker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [mppt_gt_pkg::FieldW-1:0]   volt_mv_i,
  input  logic [mppt_gt_pkg::FieldW-1:0]   curr_ma_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [mppt_gt_pkg::FieldW-1:0]   setpoint_mv_o,
  output logic                             at_peak_o,
  output logic [mppt_gt_pkg::FieldW-1:0]   peak_volt_mv_o,
  output logic [mppt_gt_pkg::FieldW-1:0]   peak_curr_ma_o,
  output logic [mppt_gt_pkg::PowerW-1:0]   peak_power_uw_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mppt_gt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mppt_gt_pkg::FieldW-1:0]   cfg_data_i
);
  import mppt_gt_pkg::*;

  state_e state_q, state_d;

  logic [FieldW-1:0] step_max_q, gain_q, deadband_q, min_sp_q, max_sp_q;
  logic [FieldW-1:0] prev_volt_q, prev_curr_q, setpoint_q;
  logic [FieldW-1:0] peak_volt_q, peak_curr_q;
  logic [PowerW-1:0] peak_power_q;
  logic              at_peak_q, out_valid_q;

  logic [FieldW-1:0]  volt_q, curr_q, dv_mag_q, di_mag_q;
  logic               quo_neg_q, dneg_q, peak_q;
  logic [FieldW-1:0]  rem_q;
  logic [QuoW-1:0]    quo_q;
  logic [DivCntW-1:0] cnt_q;
  logic [MagW-1:0]    mag_q, s_q;

  // sample differences
  logic signed [FieldW:0] dv_s, di_s, dv_neg, di_neg;
  logic                   in_acc, out_free;

  assign dv_s   = $signed({1'b0, volt_mv_i}) - $signed({1'b0, prev_volt_q});
  assign di_s   = $signed({1'b0, curr_ma_i}) - $signed({1'b0, prev_curr_q});
  assign dv_neg = -dv_s;
  assign di_neg = -di_s;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // shared multiplier
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulW-1:0]  mul_p;

  always_comb begin
    unique case (state_q)
      S_MUL: begin
        mul_a = {{(MulAW-FieldW){1'b0}}, volt_q};
        mul_b = di_mag_q;
      end
      S_GAIN: begin
        mul_a = mag_q;
        mul_b = gain_q;
      end
      default: begin
        mul_a = {{(MulAW-FieldW){1'b0}}, volt_q};
        mul_b = curr_q;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // one restoring-division step
  logic [FieldW:0] div_sh, div_diff;
  logic            div_ge;

  assign div_sh   = {rem_q, quo_q[QuoW-1]};
  assign div_diff = div_sh - {1'b0, dv_mag_q};
  assign div_ge   = (div_sh >= {1'b0, dv_mag_q});

  // derivative d = curr + q and its magnitude
  logic signed [MagW-1:0]  q_s;
  logic signed [MagW:0]    d_s, d_neg;
  logic [MagW-1:0]         d_mag;

  assign q_s   = quo_neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign d_s   = $signed({{(MagW-FieldW+1){1'b0}}, curr_q}) + $signed({q_s[MagW-1], q_s});
  assign d_neg = -d_s;
  assign d_mag = d_s[MagW] ? d_neg[MagW-1:0] : d_s[MagW-1:0];

  // final setpoint update
  logic [FieldW-1:0]        step_mag, sp_new;
  logic signed [FieldW+1:0] sp_sum, sp_lo;

  assign step_mag = (s_q > {{(MagW-FieldW){1'b0}}, step_max_q}) ? step_max_q
                                                               : s_q[FieldW-1:0];
  assign sp_sum = dneg_q ? $signed({2'b00, setpoint_q}) - $signed({2'b00, step_mag})
                         : $signed({2'b00, setpoint_q}) + $signed({2'b00, step_mag});
  assign sp_lo  = (sp_sum < $signed({2'b00, min_sp_q})) ? $signed({2'b00, min_sp_q}) : sp_sum;

  always_comb begin
    if (peak_q) begin
      sp_new = (setpoint_q < min_sp_q) ? min_sp_q : setpoint_q;
    end else if (sp_lo > $signed({2'b00, max_sp_q})) begin
      sp_new = max_sp_q;
    end else begin
      sp_new = sp_lo[FieldW-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (dv_s == '0) ? S_FIN : S_MUL;
        end
      end
      S_MUL:  state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == DivCntW'(QuoW - 1)) begin
          state_d = S_SUM;
        end
      end
      S_SUM:  state_d = S_GAIN;
      S_GAIN: state_d = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_max_q <= StepMaxRst;
      gain_q     <= GainRst;
      deadband_q <= DeadbandRst;
      min_sp_q   <= MinSpRst;
      max_sp_q   <= MaxSpRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_STEP_MAX: step_max_q <= cfg_data_i;
        REG_GAIN:     gain_q     <= cfg_data_i;
        REG_DEADBAND: deadband_q <= cfg_data_i;
        REG_MIN_SP:   min_sp_q   <= cfg_data_i;
        REG_MAX_SP:   max_sp_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // datapath working registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          volt_q    <= volt_mv_i;
          curr_q    <= curr_ma_i;
          dv_mag_q  <= dv_s[FieldW] ? dv_neg[FieldW-1:0] : dv_s[FieldW-1:0];
          di_mag_q  <= di_s[FieldW] ? di_neg[FieldW-1:0] : di_s[FieldW-1:0];
          quo_neg_q <= dv_s[FieldW] ^ di_s[FieldW];
          // unchanged voltage: full step by the sign of dI, or peak when dI is zero too
          s_q       <= {{(MagW-FieldW){1'b0}}, step_max_q};
          dneg_q    <= di_s[FieldW];
          peak_q    <= (di_s == '0);
        end
      end
      S_MUL: begin
        rem_q <= '0;
        quo_q <= mul_p[QuoW-1:0];
        cnt_q <= '0;
      end
      S_DIV: begin
        rem_q <= div_ge ? div_diff[FieldW-1:0] : div_sh[FieldW-1:0];
        quo_q <= {quo_q[QuoW-2:0], div_ge};
        cnt_q <= cnt_q + 1'b1;
      end
      S_SUM: begin
        mag_q  <= d_mag;
        dneg_q <= d_s[MagW];
        peak_q <= (d_mag <= {{(MagW-FieldW){1'b0}}, deadband_q});
      end
      S_GAIN: begin
        s_q <= mul_p[MulW-1:MulBW];
      end
      default: ;
    endcase
  end

  // tracker state and result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_volt_q  <= '0;
      prev_curr_q  <= '0;
      setpoint_q   <= '0;
      peak_volt_q  <= '0;
      peak_curr_q  <= '0;
      peak_power_q <= '0;
      at_peak_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (state_q == S_FIN && out_free) begin
        prev_volt_q <= volt_q;
        prev_curr_q <= curr_q;
        setpoint_q  <= sp_new;
        at_peak_q   <= peak_q;
        out_valid_q <= 1'b1;
        if (peak_q) begin
          peak_volt_q  <= volt_q;
          peak_curr_q  <= curr_q;
          peak_power_q <= mul_p[PowerW-1:0];
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign setpoint_mv_o   = setpoint_q;
  assign at_peak_o       = at_peak_q;
  assign peak_volt_mv_o  = peak_volt_q;
  assign peak_curr_ma_o  = peak_curr_q;
  assign peak_power_uw_o = peak_power_q;

  // checks
  a_out_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result beat raised outside the final step");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == DivCntW'(QuoW - 1)) |=> (state_q == S_SUM))
    else $error("divider did not finish after the last quotient bit");

  a_peak_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (peak_power_q == PowerW'(peak_volt_q) * PowerW'(peak_curr_q)))
    else $error("peak power does not match recorded peak point");

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && !at_peak_q && (min_sp_q <= max_sp_q))
      |-> (setpoint_q >= min_sp_q && setpoint_q <= max_sp_q))
    else $error("stepped setpoint outside limits");

endmodule
